### hdl/egpb_pkg.sv
// Shared widths, reset values, register indexes and color format codes for the glow blender.
`timescale 1ns / 1ps

package egpb_pkg;

  // Field widths
  localparam int COORD_W   = 13;
  localparam int COLOR_W   = 24;
  localparam int REC_W     = 49;
  localparam int CFG_IDX_W = 3;
  localparam int FMT_W     = 2;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int PROD_W    = 2 * SQ_W;
  localparam int Q16_W     = 17;
  localparam int WT_W      = 7;

  localparam int COORD_LIMIT_DEF = 8192;

  // Falloff constants
  localparam logic [Q16_W-1:0] Q16_ONE     = 17'd65536;
  localparam logic [WT_W-1:0]  GLOW_WEIGHT = 7'd110;

  // Register reset values
  localparam logic [COORD_W-1:0] RADIUS_X_RESET = 13'd1;
  localparam logic [COORD_W-1:0] RADIUS_Y_RESET = 13'd110;
  localparam logic [COLOR_W-1:0] GLOW_RESET     = 24'h1E4A8C;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_RADIUS_X,
    REG_RADIUS_Y,
    REG_FALLOFF_REC,
    REG_GLOW_COLOR,
    REG_PIXEL_FORMAT
  } cfg_reg_t;

  // Framebuffer encodings
  localparam logic [FMT_W-1:0] FMT_RGB888 = 2'd0;
  localparam logic [FMT_W-1:0] FMT_BGR888 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_RGB565 = 2'd2;

endpackage

### hdl/egpb_ifs.sv
// Valid/ready channel interfaces for pixels, results and configuration writes.
`timescale 1ns / 1ps

interface egpb_pix_if;
  import egpb_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [COLOR_W-1:0] base_color;

  modport source (output valid, pixel_x, pixel_y, base_color, input ready);
  modport sink   (input valid, pixel_x, pixel_y, base_color, output ready);
endinterface

interface egpb_res_if;
  import egpb_pkg::*;
  logic               valid;
  logic               ready;
  logic               inside_res;
  logic [COLOR_W-1:0] packed_color;

  modport source (output valid, inside_res, packed_color, input ready);
  modport sink   (input valid, inside_res, packed_color, output ready);
endinterface

interface egpb_cfg_if;
  import egpb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] idx;
  logic [REC_W-1:0]     wdata;

  modport source (output valid, idx, wdata, input ready);
  modport sink   (input valid, idx, wdata, output ready);
endinterface

### hdl/egpb_falloff.sv
// Three-stage falloff unit: split 52x49 product, clamp to q16, scale to blend weight.
`timescale 1ns / 1ps

module egpb_falloff (
  input  logic                             clk,
  input  logic [2:0]                       en,
  input  logic [egpb_pkg::PROD_W-1:0]      num,
  input  logic [egpb_pkg::REC_W-1:0]       rec,
  output logic [egpb_pkg::WT_W-1:0]        wt
);
  import egpb_pkg::*;

  localparam int LO_W  = 32;
  localparam int NH_W  = PROD_W - LO_W;
  localparam int RH_W  = REC_W - LO_W;
  localparam int PLL_W = 2 * LO_W;
  localparam int PHL_W = NH_W + LO_W;
  localparam int PLH_W = LO_W + RH_W;
  localparam int UP_W  = PHL_W + 1;
  localparam int WP_W  = Q16_W + WT_W;

  logic [NH_W-1:0]  nh;
  logic [LO_W-1:0]  nl;
  logic [RH_W-1:0]  rh;
  logic [LO_W-1:0]  rl;
  logic [PLL_W-1:0] pll;
  logic [PHL_W-1:0] phl;
  logic [PLH_W-1:0] plh;
  logic [UP_W-1:0]  upper;
  logic [Q16_W-1:0] q16;
  logic [WP_W-1:0]  wprod;

  logic [PLL_W-1:0] pll_r;
  logic [PHL_W-1:0] phl_r;
  logic [PLH_W-1:0] plh_r;
  logic             hh_r;
  logic [Q16_W-1:0] q16_r;
  logic [WT_W-1:0]  wt_r;

  // Split operands at bit 32 into high and low parts
  assign nh = num[PROD_W-1:LO_W];
  assign nl = num[LO_W-1:0];
  assign rh = rec[REC_W-1:LO_W];
  assign rl = rec[LO_W-1:0];

  // Partial products; the high-by-high term only matters as nonzero
  assign pll = PLL_W'(nl) * PLL_W'(rl);
  assign phl = PHL_W'(nh) * PHL_W'(rl);
  assign plh = PLH_W'(nl) * PLH_W'(rh);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pll_r <= pll;
      phl_r <= phl;
      plh_r <= plh;
      hh_r  <= (|nh) && (|rh);
    end
  end

  // Upper part of the product, saturated at one in q16
  assign upper = UP_W'(phl_r) + UP_W'(plh_r) + UP_W'(pll_r[PLL_W-1:LO_W]);
  assign q16   = (hh_r || (upper > UP_W'(Q16_ONE))) ? Q16_ONE : upper[Q16_W-1:0];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      q16_r <= q16;
    end
  end

  // Scale to the blend weight, at most the glow weight
  assign wprod = WP_W'(q16_r) * WP_W'(GLOW_WEIGHT);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      wt_r <= wprod[16 +: WT_W];
    end
  end

  assign wt = wt_r;

endmodule

### hdl/elliptical_glow_pixel_blend.sv
// Top level of the elliptical glow pixel blender: config registers, pipeline, blend and pack.
`timescale 1ns / 1ps

// Takes one pixel per clock unless stalled and returns one result per pixel, in order, through
// ten register stages: distances, squares, cross-multiplied ellipse terms, sum, compare, split
// falloff product, clamp, weight, channel blend and pack. A pixel strictly inside the ellipse
// with both coordinates below COORD_LIMIT comes back with inside_res set and the background
// blended toward the glow color by up to 110/256; any other pixel comes back as zero. Each stage
// holds only while the stage after it is full and stalled, so bubbles close up behind a stalled
// output. Configuration is taken at any time, one write per clock, but must only change while no
// pixel is in flight; falloff_reciprocal is expected as floor(2^48 / (ry^2 * rx^2)).
module elliptical_glow_pixel_blend #(
  parameter int COORD_LIMIT = egpb_pkg::COORD_LIMIT_DEF
) (
  input logic        clk,
  input logic        rst_n,
  egpb_pix_if.sink   in_pix,
  egpb_res_if.source out_res,
  egpb_cfg_if.sink   cfg_wr
);
  import egpb_pkg::*;

  localparam int NSTG    = 10;
  localparam int NTAG    = NSTG - 1;
  localparam int CMP_W   = COORD_W + 1;
  localparam int SUM_W   = PROD_W + 1;
  localparam int DIFF_W  = PROD_W + 2;
  localparam int DG_W    = 9;
  localparam int BP_W    = 17;
  localparam int CMP_STG = 4;
  localparam logic [CMP_W-1:0] LIMIT = CMP_W'(COORD_LIMIT);

  // Configuration registers
  logic [COORD_W-1:0] cx_r, cy_r, rx_r, ry_r;
  logic [REC_W-1:0]   rec_r;
  logic [COLOR_W-1:0] glow_r;
  logic [FMT_W-1:0]   fmt_r;

  // Pipeline control
  logic [NSTG-1:0] en;
  logic [NSTG-1:0] v_r;

  // Tags that ride along with each pixel
  logic [COLOR_W-1:0] base_r [NTAG];
  logic               hit_r  [NTAG];

  // Datapath
  logic [COORD_W-1:0] adx, ady;
  logic               coord_ok;
  logic [COORD_W-1:0] s0_adx_r, s0_ady_r;
  logic [SQ_W-1:0]    adx2, ady2, rx2, ry2;
  logic [SQ_W-1:0]    s1_adx2_r, s1_ady2_r, s1_rx2_r, s1_ry2_r;
  logic [PROD_W-1:0]  t1, t2, den;
  logic [PROD_W-1:0]  s2_t1_r, s2_t2_r, s2_den_r;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   s3_sum_r;
  logic [PROD_W-1:0]  s3_den_r;
  logic [DIFF_W-1:0]  diff;
  logic               s4_inside;
  logic [PROD_W-1:0]  s4_num_r;
  logic [WT_W-1:0]    wt;
  logic signed [BP_W-1:0] bprod   [3];
  logic signed [BP_W-1:0] s8_bp_r [3];
  logic [7:0]         chan [3];
  logic [COLOR_W-1:0] packed_px;
  logic               s9_in_r;
  logic [COLOR_W-1:0] s9_pack_r;

  function automatic logic [COLOR_W-1:0] pack_px(input logic [FMT_W-1:0] fmt,
                                                 input logic [7:0] r,
                                                 input logic [7:0] g,
                                                 input logic [7:0] b);
    logic [COLOR_W-1:0] res;
    case (fmt)
      FMT_RGB888: res = {r, g, b};
      FMT_BGR888: res = {b, g, r};
      FMT_RGB565: res = {8'h00, r[7:3], g[7:2], b[7:3]};
      default:    res = {r, g, b};
    endcase
    return res;
  endfunction

  // Configuration writes; unknown indexes drop
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= '0;
      cy_r   <= '0;
      rx_r   <= RADIUS_X_RESET;
      ry_r   <= RADIUS_Y_RESET;
      rec_r  <= '0;
      glow_r <= GLOW_RESET;
      fmt_r  <= FMT_RGB888;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.idx)
        REG_CENTER_X:     cx_r   <= cfg_wr.wdata[COORD_W-1:0];
        REG_CENTER_Y:     cy_r   <= cfg_wr.wdata[COORD_W-1:0];
        REG_RADIUS_X:     rx_r   <= cfg_wr.wdata[COORD_W-1:0];
        REG_RADIUS_Y:     ry_r   <= cfg_wr.wdata[COORD_W-1:0];
        REG_FALLOFF_REC:  rec_r  <= cfg_wr.wdata;
        REG_GLOW_COLOR:   glow_r <= cfg_wr.wdata[COLOR_W-1:0];
        REG_PIXEL_FORMAT: fmt_r  <= cfg_wr.wdata[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when empty or when the stage after it moves
  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_res.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_pix.ready = en[0];

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_pix.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Carry background color and hit flag; the hit flag is replaced at the compare stage
  always_ff @(posedge clk) begin
    if (en[0]) begin
      base_r[0] <= in_pix.base_color;
      hit_r[0]  <= coord_ok;
    end
    for (int k = 1; k < NTAG; k++) begin
      if (en[k]) begin
        base_r[k] <= base_r[k-1];
        hit_r[k]  <= (k == CMP_STG) ? s4_inside : hit_r[k-1];
      end
    end
  end

  // Stage 0: distances from the center, coordinate range check
  assign adx = (in_pix.pixel_x >= cx_r) ? in_pix.pixel_x - cx_r : cx_r - in_pix.pixel_x;
  assign ady = (in_pix.pixel_y >= cy_r) ? in_pix.pixel_y - cy_r : cy_r - in_pix.pixel_y;
  assign coord_ok = ({1'b0, in_pix.pixel_x} < LIMIT) && ({1'b0, in_pix.pixel_y} < LIMIT);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_adx_r <= adx;
      s0_ady_r <= ady;
    end
  end

  // Stage 1: squares of distances and radii
  assign adx2 = SQ_W'(s0_adx_r) * SQ_W'(s0_adx_r);
  assign ady2 = SQ_W'(s0_ady_r) * SQ_W'(s0_ady_r);
  assign rx2  = SQ_W'(rx_r) * SQ_W'(rx_r);
  assign ry2  = SQ_W'(ry_r) * SQ_W'(ry_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_adx2_r <= adx2;
      s1_ady2_r <= ady2;
      s1_rx2_r  <= rx2;
      s1_ry2_r  <= ry2;
    end
  end

  // Stage 2: cross-multiplied ellipse terms
  assign t1  = PROD_W'(s1_adx2_r) * PROD_W'(s1_ry2_r);
  assign t2  = PROD_W'(s1_ady2_r) * PROD_W'(s1_rx2_r);
  assign den = PROD_W'(s1_ry2_r) * PROD_W'(s1_rx2_r);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_t1_r  <= t1;
      s2_t2_r  <= t2;
      s2_den_r <= den;
    end
  end

  // Stage 3: weighted distance sum
  assign sum = SUM_W'(s2_t1_r) + SUM_W'(s2_t2_r);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_sum_r <= sum;
      s3_den_r <= s2_den_r;
    end
  end

  // Stage 4: strict inside test and falloff numerator
  assign diff      = DIFF_W'(s3_den_r) - DIFF_W'(s3_sum_r);
  assign s4_inside = hit_r[CMP_STG-1] && !diff[DIFF_W-1] && (diff[SUM_W-1:0] != '0);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_num_r <= diff[PROD_W-1:0];
    end
  end

  // Stages 5 to 7: falloff and blend weight
  egpb_falloff u_falloff (
    .clk (clk),
    .en  (en[7:5]),
    .num (s4_num_r),
    .rec (rec_r),
    .wt  (wt)
  );

  // Stage 8: per-channel signed difference times weight
  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic signed [DG_W-1:0] dg;
    logic signed [DG_W-1:0] ws;
    logic signed [BP_W-1:0] sh;

    assign dg = $signed({1'b0, glow_r[8*c +: 8]}) - $signed({1'b0, base_r[7][8*c +: 8]});
    assign ws = $signed({2'b00, wt});
    assign bprod[c] = BP_W'(dg) * BP_W'(ws);

    always_ff @(posedge clk) begin
      if (en[8]) begin
        s8_bp_r[c] <= bprod[c];
      end
    end

    // Floor shift, wrap into eight bits
    assign sh      = s8_bp_r[c] >>> 8;
    assign chan[c] = base_r[8][8*c +: 8] + sh[7:0];
  end

  // Stage 9: pack into the framebuffer encoding, zero when outside
  assign packed_px = pack_px(fmt_r, chan[2], chan[1], chan[0]);

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_in_r   <= hit_r[8];
      s9_pack_r <= hit_r[8] ? packed_px : '0;
    end
  end

  assign out_res.valid        = v_r[NSTG-1];
  assign out_res.inside_res   = s9_in_r;
  assign out_res.packed_color = s9_pack_r;

`ifndef SYNTHESIS
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.inside_res |-> out_res.packed_color == '0)
    else $error("outside pixel carries nonzero color");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[7] |-> wt <= GLOW_WEIGHT)
    else $error("blend weight above glow weight");

  a_rgb565_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && fmt_r == FMT_RGB565 |-> out_res.packed_color[23:16] == 8'h00)
    else $error("RGB565 result has upper byte set");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[8] && !en[8] |=> v_r[8] && $stable(base_r[8]) && $stable(hit_r[8]))
    else $error("stalled blend stage lost its pixel");
`endif

endmodule
